@@ src/dh_forward_kinematics_chain_assert.svh @@
// Assertion macros shared by the kinematics chain RTL.
`ifndef DH_FORWARD_KINEMATICS_CHAIN_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_ASSERT_SVH

// The condition a at one edge implies b at the next edge.
`define DHFK_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("next-cycle check failed");

// The condition a at one edge implies b at the same edge.
`define DHFK_ASSERT_SAME(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("same-cycle check failed");

`endif

@@ src/dhfk_pkg.sv @@
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types, constants and helper functions of the kinematics chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhfk_pkg;

    // One set of link parameters.
    typedef struct packed {
        logic [3:0]         link_index;
        logic [15:0]        joint_angle;
        logic [15:0]        link_twist;
        logic signed [31:0] link_length;
        logic signed [31:0] link_offset;
        logic               end_of_chain;
    } in_item_t;

    // One pose result.
    typedef struct packed {
        logic signed [31:0] rot_00;
        logic signed [31:0] rot_01;
        logic signed [31:0] rot_02;
        logic signed [31:0] rot_10;
        logic signed [31:0] rot_11;
        logic signed [31:0] rot_12;
        logic signed [31:0] rot_20;
        logic signed [31:0] rot_21;
        logic signed [31:0] rot_22;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
    } out_item_t;

    // Register indexes of the configuration port.
    localparam logic [0:0] CFG_FIRST_LINK = 1'b0;
    localparam logic [0:0] CFG_LAST_LINK  = 1'b1;

    // Fixed-point constants.
    localparam logic [63:0]        ANGLE_STEP_Q62 = 64'h0000_C90F_DAA2_2169;
    localparam logic [63:0]        Q62_ONE        = 64'h4000_0000_0000_0000;
    localparam logic signed [31:0] Q30_ONE        = 32'sh4000_0000;
    localparam logic [3:0]         SERIES_TERMS   = 4'd12;

    // Operand selects of the wide (series) multiply.
    typedef enum logic [1:0] {WA_ANGLE, WA_X, WA_ST, WA_CT} wide_a_t;
    typedef enum logic [1:0] {WB_STEP, WB_X, WB_X2} wide_b_t;

    // Operand selects of the Q30 multiply.
    typedef enum logic [2:0] {FA_ROT, FA_NSTH, FA_STH, FA_CTH, FA_NCTH, FA_LEN} fix_a_t;
    typedef enum logic [2:0] {FB_CA, FB_SA, FB_CTH, FB_STH, FB_LR, FB_LP} fix_b_t;

    // Register write operations of the datapath.
    typedef enum logic [3:0] {
        WR_NONE, WR_X, WR_X2, WR_DIV, WR_ST, WR_CT, WR_TRIG, WR_LR_INIT,
        WR_LR, WR_LP, WR_NROT, WR_NPOS, WR_COMMIT, WR_EMIT, WR_RESET
    } wr_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_X, ST_X2, ST_TERM_S, ST_DIV_S, ST_TERM_C, ST_DIV_C,
        ST_TRIG, ST_LINK, ST_ROT, ST_POS, ST_COMMIT, ST_EMIT, ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       mul_en;
        logic       mul_wide;
        logic [1:0] pp;
        wide_a_t    wa;
        wide_b_t    wb;
        fix_a_t     fa;
        fix_b_t     fb;
        logic [3:0] rot_idx;
        logic [3:0] lr_idx;
        logic [1:0] lp_idx;
        logic [1:0] pos_idx;
        logic       acc_clr;
        logic       acc_load_pos;
        logic       angle_sel;
        logic       term_odd;
        logic       div_cos;
        logic [3:0] term_k;
        wr_op_t     wr_op;
        logic [3:0] wr_idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] link_index;
        logic       end_of_chain;
        logic       div_busy;
        logic       out_full;
    } stat_t;

    // Divisor of series term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
    function automatic logic [9:0] series_divisor(logic [3:0] k, logic is_cos);
        logic [9:0] k2;
        k2 = {5'b0, k, 1'b0};
        if (is_cos) begin
            return 10'((k2 - 10'd1) * k2);
        end
        return 10'(k2 * (k2 + 10'd1));
    endfunction

endpackage

`default_nettype wire

@@ src/dhfk_div.sv @@
// ----------------------------------------------------------------------------
// dhfk_div
// Unsigned 64-bit by 10-bit divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhfk_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [9:0]  divisor,
    output logic             busy,
    output logic [63:0]      quotient
);

    localparam int DIGITS = 4;

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [63:0] quo_reg;
    logic [9:0]  rem_reg;
    logic [9:0]  den_reg;
    logic [9:0]  rem_next;
    logic [3:0]  qd;

    // Four restoring steps on the narrow remainder.
    always_comb begin
        logic [10:0] r;
        r = {1'b0, rem_reg};
        qd = '0;
        for (int i = 0; i < DIGITS; i++) begin
            r = {r[9:0], num_reg[63 - i]};
            if (r >= {1'b0, den_reg}) begin
                r = r - {1'b0, den_reg};
                qd[DIGITS - 1 - i] = 1'b1;
            end
        end
        rem_next = r[9:0];
    end

    // Busy flag and iteration count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd15;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shifting dividend, remainder and quotient.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[59:0], 4'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[59:0], qd};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ src/dhfk_datapath.sv @@
// ----------------------------------------------------------------------------
// dhfk_datapath
// Shared multiplier, accumulators, sine and cosine series registers, link transform
// and pose registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhfk_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dhfk_pkg::cmd_t      cmd,
    input  wire dhfk_pkg::in_item_t  s_data,
    input  wire logic                m_ready,
    output dhfk_pkg::stat_t          stat,
    output dhfk_pkg::out_item_t      m_data,
    output logic                     m_valid
);

    localparam logic signed [49:0] ROT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] ROT_MIN = -50'sd2147483648;
    localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;

    dhfk_pkg::in_item_t  item_reg;
    dhfk_pkg::out_item_t out_reg;
    logic                out_vld_reg;

    logic [63:0] x_reg, x2_reg, st_reg, ct_reg, ss_reg, cs_reg;
    logic signed [31:0] sth_reg, cth_reg, sa_reg, ca_reg;
    logic signed [31:0] lr_reg [9];
    logic signed [32:0] lp_reg [3];
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] nrot_reg [9];
    logic signed [47:0] pos_reg [3];
    logic signed [47:0] npos_reg [3];

    logic signed [65:0] prod_reg;
    logic               prod_vld_reg;
    logic               prod_wide_reg;
    logic [1:0]         prod_sh_reg;
    logic [127:0]       wacc_reg;
    logic signed [49:0] facc_reg;

    logic [13:0]        angle14;
    logic [1:0]         quad;
    logic [63:0]        wa64, wb64;
    logic [31:0]        a32, b32;
    logic signed [32:0] fa33, fb33;
    logic signed [32:0] mul_x, mul_y;
    logic signed [65:0] prod_c;
    logic [127:0]       wterm;
    logic signed [65:0] rnd_full;
    logic signed [49:0] rnd50;
    logic [63:0]        q62;
    logic [63:0]        sr, cr;
    logic signed [31:0] s_rnd, c_rnd, s_q, c_q;
    logic signed [31:0] sat_rot;
    logic signed [47:0] sat_pos;
    logic               div_busy;
    logic [63:0]        div_quo;

    // Angle under work and its quadrant.
    assign angle14 = cmd.angle_sel ? item_reg.link_twist[13:0] : item_reg.joint_angle[13:0];
    assign quad    = cmd.angle_sel ? item_reg.link_twist[15:14] : item_reg.joint_angle[15:14];

    // Wide operand selection, one 32-bit half of each per partial product.
    always_comb begin
        case (cmd.wa)
            dhfk_pkg::WA_ANGLE: wa64 = {50'b0, angle14};
            dhfk_pkg::WA_X:     wa64 = x_reg;
            dhfk_pkg::WA_ST:    wa64 = st_reg;
            dhfk_pkg::WA_CT:    wa64 = ct_reg;
            default:            wa64 = '0;
        endcase
        case (cmd.wb)
            dhfk_pkg::WB_STEP: wb64 = dhfk_pkg::ANGLE_STEP_Q62;
            dhfk_pkg::WB_X:    wb64 = x_reg;
            dhfk_pkg::WB_X2:   wb64 = x2_reg;
            default:           wb64 = '0;
        endcase
        a32 = cmd.pp[1] ? wa64[63:32] : wa64[31:0];
        b32 = cmd.pp[0] ? wb64[63:32] : wb64[31:0];
    end

    // Q30 operand selection.
    always_comb begin
        case (cmd.fa)
            dhfk_pkg::FA_ROT:  fa33 = 33'(rot_reg[cmd.rot_idx]);
            dhfk_pkg::FA_NSTH: fa33 = -33'(sth_reg);
            dhfk_pkg::FA_STH:  fa33 = 33'(sth_reg);
            dhfk_pkg::FA_CTH:  fa33 = 33'(cth_reg);
            dhfk_pkg::FA_NCTH: fa33 = -33'(cth_reg);
            dhfk_pkg::FA_LEN:  fa33 = 33'(item_reg.link_length);
            default:           fa33 = '0;
        endcase
        case (cmd.fb)
            dhfk_pkg::FB_CA:  fb33 = 33'(ca_reg);
            dhfk_pkg::FB_SA:  fb33 = 33'(sa_reg);
            dhfk_pkg::FB_CTH: fb33 = 33'(cth_reg);
            dhfk_pkg::FB_STH: fb33 = 33'(sth_reg);
            dhfk_pkg::FB_LR:  fb33 = 33'(lr_reg[cmd.lr_idx]);
            dhfk_pkg::FB_LP:  fb33 = lp_reg[cmd.lp_idx];
            default:          fb33 = '0;
        endcase
    end

    // The one shared multiplier.
    assign mul_x  = cmd.mul_wide ? $signed({1'b0, a32}) : fa33;
    assign mul_y  = cmd.mul_wide ? $signed({1'b0, b32}) : fb33;
    assign prod_c = mul_x * mul_y;

    // Placement of a partial product in the wide accumulator.
    always_comb begin
        case (prod_sh_reg)
            2'd0:    wterm = {64'b0, prod_reg[63:0]};
            2'd1:    wterm = {32'b0, prod_reg[63:0], 32'b0};
            default: wterm = {prod_reg[63:0], 64'b0};
        endcase
    end

    // Q30 rounding to nearest, ties up.
    assign rnd_full = prod_reg + 66'sd536870912;
    assign rnd50    = 50'($signed(rnd_full[65:30]));

    // Q2.62 product rounded from the wide accumulator.
    assign q62 = wacc_reg[125:62] + {63'b0, wacc_reg[61]};

    // Sine and cosine rounded to Q2.30 and folded into their quadrant.
    assign sr    = ss_reg + 64'h0000_0000_8000_0000;
    assign cr    = cs_reg + 64'h0000_0000_8000_0000;
    assign s_rnd = $signed(sr[63:32]);
    assign c_rnd = $signed(cr[63:32]);
    always_comb begin
        case (quad)
            2'd0:    begin s_q = s_rnd;  c_q = c_rnd;  end
            2'd1:    begin s_q = c_rnd;  c_q = -s_rnd; end
            2'd2:    begin s_q = -s_rnd; c_q = -c_rnd; end
            default: begin s_q = -c_rnd; c_q = s_rnd;  end
        endcase
    end

    // Saturation of the accumulated sums.
    always_comb begin
        if (facc_reg > ROT_MAX) begin
            sat_rot = 32'(ROT_MAX);
        end else if (facc_reg < ROT_MIN) begin
            sat_rot = 32'(ROT_MIN);
        end else begin
            sat_rot = facc_reg[31:0];
        end
        if (facc_reg > POS_MAX) begin
            sat_pos = 48'(POS_MAX);
        end else if (facc_reg < POS_MIN) begin
            sat_pos = 48'(POS_MIN);
        end else begin
            sat_pos = facc_reg[47:0];
        end
    end

    // Series divider.
    dhfk_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.wr_op == dhfk_pkg::WR_DIV),
        .dividend (q62),
        .divisor  (dhfk_pkg::series_divisor(cmd.term_k, cmd.div_cos)),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Pose, output valid and product valid: state with a reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                rot_reg[i] <= (i % 4 == 0) ? dhfk_pkg::Q30_ONE : '0;
            end
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
            end
            out_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
            if (cmd.wr_op == dhfk_pkg::WR_EMIT) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            case (cmd.wr_op)
                dhfk_pkg::WR_COMMIT: begin
                    rot_reg <= nrot_reg;
                    pos_reg <= npos_reg;
                end
                dhfk_pkg::WR_EMIT, dhfk_pkg::WR_RESET: begin
                    for (int i = 0; i < 9; i++) begin
                        rot_reg[i] <= (i % 4 == 0) ? dhfk_pkg::Q30_ONE : '0;
                    end
                    for (int i = 0; i < 3; i++) begin
                        pos_reg[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers of the item, the product and the accumulators.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        prod_reg      <= prod_c;
        prod_wide_reg <= cmd.mul_wide;
        prod_sh_reg   <= {1'b0, cmd.pp[1]} + {1'b0, cmd.pp[0]};
        if (cmd.acc_clr) begin
            wacc_reg <= '0;
            facc_reg <= '0;
        end else if (cmd.acc_load_pos) begin
            facc_reg <= 50'(pos_reg[cmd.pos_idx]);
        end else if (prod_vld_reg) begin
            if (prod_wide_reg) begin
                wacc_reg <= wacc_reg + wterm;
            end else begin
                facc_reg <= facc_reg + rnd50;
            end
        end
    end

    // Register writes ordered by the controller.
    always_ff @(posedge aclk) begin
        case (cmd.wr_op)
            dhfk_pkg::WR_X: begin
                x_reg  <= wacc_reg[63:0];
                st_reg <= wacc_reg[63:0];
                ss_reg <= wacc_reg[63:0];
                ct_reg <= dhfk_pkg::Q62_ONE;
                cs_reg <= dhfk_pkg::Q62_ONE;
            end
            dhfk_pkg::WR_X2: x2_reg <= q62;
            dhfk_pkg::WR_ST: begin
                st_reg <= div_quo;
                ss_reg <= cmd.term_odd ? ss_reg - div_quo : ss_reg + div_quo;
            end
            dhfk_pkg::WR_CT: begin
                ct_reg <= div_quo;
                cs_reg <= cmd.term_odd ? cs_reg - div_quo : cs_reg + div_quo;
            end
            dhfk_pkg::WR_TRIG: begin
                if (cmd.angle_sel) begin
                    sa_reg <= s_q;
                    ca_reg <= c_q;
                end else begin
                    sth_reg <= s_q;
                    cth_reg <= c_q;
                end
            end
            dhfk_pkg::WR_LR_INIT: begin
                lr_reg[0] <= cth_reg;
                lr_reg[3] <= sth_reg;
                lr_reg[6] <= '0;
                lr_reg[7] <= sa_reg;
                lr_reg[8] <= ca_reg;
                lp_reg[2] <= 33'(item_reg.link_offset);
            end
            dhfk_pkg::WR_LR:   lr_reg[cmd.wr_idx] <= facc_reg[31:0];
            dhfk_pkg::WR_LP:   lp_reg[cmd.wr_idx[1:0]] <= facc_reg[32:0];
            dhfk_pkg::WR_NROT: nrot_reg[cmd.wr_idx] <= sat_rot;
            dhfk_pkg::WR_NPOS: npos_reg[cmd.wr_idx[1:0]] <= sat_pos;
            dhfk_pkg::WR_EMIT: begin
                out_reg.rot_00 <= rot_reg[0];
                out_reg.rot_01 <= rot_reg[1];
                out_reg.rot_02 <= rot_reg[2];
                out_reg.rot_10 <= rot_reg[3];
                out_reg.rot_11 <= rot_reg[4];
                out_reg.rot_12 <= rot_reg[5];
                out_reg.rot_20 <= rot_reg[6];
                out_reg.rot_21 <= rot_reg[7];
                out_reg.rot_22 <= rot_reg[8];
                out_reg.pos_x  <= pos_reg[0];
                out_reg.pos_y  <= pos_reg[1];
                out_reg.pos_z  <= pos_reg[2];
            end
            default: begin
            end
        endcase
    end

    // Status and result outputs.
    assign stat.link_index   = item_reg.link_index;
    assign stat.end_of_chain = item_reg.end_of_chain;
    assign stat.div_busy     = div_busy;
    assign stat.out_full     = out_vld_reg;
    assign m_data            = out_reg;
    assign m_valid           = out_vld_reg;

endmodule

`default_nettype wire

@@ src/dhfk_ctrl.sv @@
// ----------------------------------------------------------------------------
// dhfk_ctrl
// Sequencer of the chain: item decision, sine and cosine series, link transform,
// pose product, result hand-off and the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhfk_ctrl #(
    parameter int MAX_LINKS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            cfg_wr_en,
    input  wire logic [0:0]      cfg_addr,
    input  wire logic [3:0]      cfg_wdata,
    input  wire dhfk_pkg::stat_t stat,
    output dhfk_pkg::cmd_t       cmd
);

    dhfk_pkg::state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] m_reg, m_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [3:0] k_reg, k_next;
    logic       ang_reg, ang_next;
    logic       emit_reg, emit_next;
    logic       fin_reg, fin_next;
    logic [3:0] first_reg, last_reg;
    logic       active, apply, emit;

    // Item decision against the configured range.
    assign active = !fin_reg && (last_reg >= first_reg);
    assign apply  = active && (stat.link_index >= first_reg) &&
                    (stat.link_index <= last_reg) && (int'(stat.link_index) < MAX_LINKS);
    assign emit   = active && ((stat.link_index == last_reg) || stat.end_of_chain);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 4'd0;
            last_reg  <= 4'd15;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dhfk_pkg::CFG_FIRST_LINK: first_reg <= cfg_wdata;
                dhfk_pkg::CFG_LAST_LINK:  last_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dhfk_pkg::ST_IDLE;
            step_reg  <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            ang_reg   <= 1'b0;
            emit_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            m_reg     <= m_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            ang_reg   <= ang_next;
            emit_reg  <= emit_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg + 3'd1;
        m_next     = m_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ang_next   = ang_reg;
        emit_next  = emit_reg;
        fin_next   = fin_reg;
        case (state_reg)
            dhfk_pkg::ST_IDLE: begin
                step_next = '0;
                if (s_valid) begin
                    state_next = dhfk_pkg::ST_DECIDE;
                end
            end
            dhfk_pkg::ST_DECIDE: begin
                step_next = '0;
                emit_next = emit;
                ang_next  = 1'b0;
                if (apply) begin
                    state_next = dhfk_pkg::ST_X;
                end else if (emit) begin
                    state_next = dhfk_pkg::ST_EMIT;
                end else begin
                    state_next = dhfk_pkg::ST_FINISH;
                end
            end
            dhfk_pkg::ST_X: begin
                if (step_reg == 3'd5) begin
                    step_next  = '0;
                    state_next = dhfk_pkg::ST_X2;
                end
            end
            dhfk_pkg::ST_X2: begin
                if (step_reg == 3'd5) begin
                    step_next  = '0;
                    k_next     = 4'd1;
                    state_next = dhfk_pkg::ST_TERM_S;
                end
            end
            dhfk_pkg::ST_TERM_S: begin
                if (step_reg == 3'd5) begin
                    step_next  = '0;
                    state_next = dhfk_pkg::ST_DIV_S;
                end
            end
            dhfk_pkg::ST_DIV_S: begin
                step_next = '0;
                if (!stat.div_busy) begin
                    state_next = dhfk_pkg::ST_TERM_C;
                end
            end
            dhfk_pkg::ST_TERM_C: begin
                if (step_reg == 3'd5) begin
                    step_next  = '0;
                    state_next = dhfk_pkg::ST_DIV_C;
                end
            end
            dhfk_pkg::ST_DIV_C: begin
                step_next = '0;
                if (!stat.div_busy) begin
                    if (k_reg == dhfk_pkg::SERIES_TERMS) begin
                        state_next = dhfk_pkg::ST_TRIG;
                    end else begin
                        k_next     = k_reg + 4'd1;
                        state_next = dhfk_pkg::ST_TERM_S;
                    end
                end
            end
            dhfk_pkg::ST_TRIG: begin
                step_next = '0;
                if (!ang_reg) begin
                    ang_next   = 1'b1;
                    state_next = dhfk_pkg::ST_X;
                end else begin
                    m_next     = '0;
                    state_next = dhfk_pkg::ST_LINK;
                end
            end
            dhfk_pkg::ST_LINK: begin
                if (step_reg == 3'd2) begin
                    step_next = '0;
                    if (m_reg == 3'd5) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = dhfk_pkg::ST_ROT;
                    end else begin
                        m_next = m_reg + 3'd1;
                    end
                end
            end
            dhfk_pkg::ST_ROT: begin
                if (step_reg == 3'd4) begin
                    step_next = '0;
                    if (j_reg == 2'd2) begin
                        j_next = '0;
                        if (i_reg == 2'd2) begin
                            i_next     = '0;
                            state_next = dhfk_pkg::ST_POS;
                        end else begin
                            i_next = i_reg + 2'd1;
                        end
                    end else begin
                        j_next = j_reg + 2'd1;
                    end
                end
            end
            dhfk_pkg::ST_POS: begin
                if (step_reg == 3'd4) begin
                    step_next = '0;
                    if (i_reg == 2'd2) begin
                        state_next = dhfk_pkg::ST_COMMIT;
                    end else begin
                        i_next = i_reg + 2'd1;
                    end
                end
            end
            dhfk_pkg::ST_COMMIT: begin
                step_next  = '0;
                state_next = emit_reg ? dhfk_pkg::ST_EMIT : dhfk_pkg::ST_FINISH;
            end
            dhfk_pkg::ST_EMIT: begin
                step_next = '0;
                if (!stat.out_full) begin
                    fin_next   = !stat.end_of_chain;
                    state_next = dhfk_pkg::ST_FINISH;
                end
            end
            dhfk_pkg::ST_FINISH: begin
                step_next = '0;
                if (stat.end_of_chain) begin
                    fin_next = 1'b0;
                end
                state_next = dhfk_pkg::ST_IDLE;
            end
            default: begin
                step_next  = '0;
                state_next = dhfk_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands for each state.
    always_comb begin
        cmd           = '0;
        cmd.wa        = dhfk_pkg::WA_ANGLE;
        cmd.wb        = dhfk_pkg::WB_STEP;
        cmd.fa        = dhfk_pkg::FA_ROT;
        cmd.fb        = dhfk_pkg::FB_LR;
        cmd.wr_op     = dhfk_pkg::WR_NONE;
        cmd.angle_sel = ang_reg;
        cmd.term_k    = k_reg;
        cmd.term_odd  = k_reg[0];
        cmd.pp        = step_reg[1:0];
        cmd.pos_idx   = i_reg;
        case (state_reg)
            dhfk_pkg::ST_IDLE: begin
                cmd.load_item = s_valid;
            end
            dhfk_pkg::ST_X, dhfk_pkg::ST_X2, dhfk_pkg::ST_TERM_S, dhfk_pkg::ST_TERM_C: begin
                // Four partial products, the last accumulate, then the write.
                cmd.mul_wide = 1'b1;
                cmd.mul_en   = (step_reg < 3'd4);
                cmd.acc_clr  = (step_reg == 3'd0);
                case (state_reg)
                    dhfk_pkg::ST_X: begin
                        cmd.wa = dhfk_pkg::WA_ANGLE;
                        cmd.wb = dhfk_pkg::WB_STEP;
                        if (step_reg == 3'd5) cmd.wr_op = dhfk_pkg::WR_X;
                    end
                    dhfk_pkg::ST_X2: begin
                        cmd.wa = dhfk_pkg::WA_X;
                        cmd.wb = dhfk_pkg::WB_X;
                        if (step_reg == 3'd5) cmd.wr_op = dhfk_pkg::WR_X2;
                    end
                    dhfk_pkg::ST_TERM_S: begin
                        cmd.wa      = dhfk_pkg::WA_ST;
                        cmd.wb      = dhfk_pkg::WB_X2;
                        cmd.div_cos = 1'b0;
                        if (step_reg == 3'd5) cmd.wr_op = dhfk_pkg::WR_DIV;
                    end
                    default: begin
                        cmd.wa      = dhfk_pkg::WA_CT;
                        cmd.wb      = dhfk_pkg::WB_X2;
                        cmd.div_cos = 1'b1;
                        if (step_reg == 3'd5) cmd.wr_op = dhfk_pkg::WR_DIV;
                    end
                endcase
            end
            dhfk_pkg::ST_DIV_S: begin
                if (!stat.div_busy) cmd.wr_op = dhfk_pkg::WR_ST;
            end
            dhfk_pkg::ST_DIV_C: begin
                if (!stat.div_busy) cmd.wr_op = dhfk_pkg::WR_CT;
            end
            dhfk_pkg::ST_TRIG: begin
                cmd.wr_op = dhfk_pkg::WR_TRIG;
            end
            dhfk_pkg::ST_LINK: begin
                // Single rounded products of the link transform.
                cmd.mul_en  = (step_reg == 3'd0);
                cmd.acc_clr = (step_reg == 3'd0);
                case (m_reg)
                    3'd0: begin
                        cmd.fa = dhfk_pkg::FA_NSTH; cmd.fb = dhfk_pkg::FB_CA;
                        cmd.wr_idx = 4'd1;
                    end
                    3'd1: begin
                        cmd.fa = dhfk_pkg::FA_STH;  cmd.fb = dhfk_pkg::FB_SA;
                        cmd.wr_idx = 4'd2;
                    end
                    3'd2: begin
                        cmd.fa = dhfk_pkg::FA_CTH;  cmd.fb = dhfk_pkg::FB_CA;
                        cmd.wr_idx = 4'd4;
                    end
                    3'd3: begin
                        cmd.fa = dhfk_pkg::FA_NCTH; cmd.fb = dhfk_pkg::FB_SA;
                        cmd.wr_idx = 4'd5;
                    end
                    3'd4: begin
                        cmd.fa = dhfk_pkg::FA_LEN;  cmd.fb = dhfk_pkg::FB_CTH;
                        cmd.wr_idx = 4'd0;
                    end
                    default: begin
                        cmd.fa = dhfk_pkg::FA_LEN;  cmd.fb = dhfk_pkg::FB_STH;
                        cmd.wr_idx = 4'd1;
                    end
                endcase
                if (step_reg == 3'd0 && m_reg == 3'd0) begin
                    cmd.wr_op = dhfk_pkg::WR_LR_INIT;
                end else if (step_reg == 3'd2) begin
                    cmd.wr_op = (m_reg >= 3'd4) ? dhfk_pkg::WR_LP : dhfk_pkg::WR_LR;
                end
            end
            dhfk_pkg::ST_ROT: begin
                // Row i of the pose times column j of the link rotation.
                cmd.mul_en  = (step_reg < 3'd3);
                cmd.acc_clr = (step_reg == 3'd0);
                cmd.fa      = dhfk_pkg::FA_ROT;
                cmd.fb      = dhfk_pkg::FB_LR;
                cmd.rot_idx = 4'(i_reg * 3) + 4'(step_reg[1:0]);
                cmd.lr_idx  = 4'(step_reg[1:0] * 3) + 4'(j_reg);
                cmd.wr_idx  = 4'(i_reg * 3) + 4'(j_reg);
                if (step_reg == 3'd4) cmd.wr_op = dhfk_pkg::WR_NROT;
            end
            dhfk_pkg::ST_POS: begin
                // Row i of the pose times the link offset, on top of the old position.
                cmd.mul_en       = (step_reg < 3'd3);
                cmd.acc_load_pos = (step_reg == 3'd0);
                cmd.fa           = dhfk_pkg::FA_ROT;
                cmd.fb           = dhfk_pkg::FB_LP;
                cmd.rot_idx      = 4'(i_reg * 3) + 4'(step_reg[1:0]);
                cmd.lp_idx       = step_reg[1:0];
                cmd.wr_idx       = 4'(i_reg);
                if (step_reg == 3'd4) cmd.wr_op = dhfk_pkg::WR_NPOS;
            end
            dhfk_pkg::ST_COMMIT: begin
                cmd.wr_op = dhfk_pkg::WR_COMMIT;
            end
            dhfk_pkg::ST_EMIT: begin
                if (!stat.out_full) cmd.wr_op = dhfk_pkg::WR_EMIT;
            end
            dhfk_pkg::ST_FINISH: begin
                if (stat.end_of_chain) cmd.wr_op = dhfk_pkg::WR_RESET;
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == dhfk_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ src/dh_forward_kinematics_chain.sv @@
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Denavit-Hartenberg forward kinematics over a chain of links, fixed point.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                        Moves
//   input    s_valid s_ready s_data       one item of link parameters
//   result   m_valid m_ready m_data       one item of pose rotation and position
//   config   cfg_wr_en cfg_addr cfg_wdata first_link and last_link writes
//
// For an item that is applied, the sine and cosine series of both angles,
// twelve terms each, dominate the work, with four partial products on the
// shared multiplier and two divides per term; the link transform and the
// pose product follow. An item that is not applied skips all of this.
// Reset is synchronous and active low and needs no clearing pass.
// A waiting result does not stop the next item; only a second result waits for it.
`timescale 1ns / 1ps
`default_nettype none
`include "dh_forward_kinematics_chain_assert.svh"

module dh_forward_kinematics_chain #(
    parameter int MAX_LINKS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dhfk_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dhfk_pkg::out_item_t      m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [0:0]          cfg_addr,
    input  wire logic [3:0]          cfg_wdata
);

    dhfk_pkg::cmd_t  cmd;
    dhfk_pkg::stat_t stat;

    // Sequencer.
    dhfk_ctrl #(
        .MAX_LINKS (MAX_LINKS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and pose storage.
    dhfk_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .stat    (stat),
        .m_data  (m_data),
        .m_valid (m_valid)
    );

    // The block goes busy after taking an item.
    `DHFK_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A new result appears only while an item is at work.
    `DHFK_ASSERT_SAME(a_result_from_work, aclk, aresetn, $rose(m_valid), $past(!s_ready))

endmodule

`default_nettype wire
